// ===== hw/rtl/two_class_priority_order_queue_defines.svh =====
// ----------------------------------------------------------------------------
// two_class_priority_order_queue defines
// assertion macros shared by the order queue rtl
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_PRIORITY_ORDER_QUEUE_DEFINES_SVH
`define TWO_CLASS_PRIORITY_ORDER_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define TCPQ_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("tcpq assertion failed");

`define TCPQ_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("tcpq assertion failed");

`else

`define TCPQ_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)

`define TCPQ_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// ===== hw/rtl/tcpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpq_pkg
// sizes, codes and shared types of the two class order queue
// ----------------------------------------------------------------------------
package tcpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MENU_SIZE   = 4;
    localparam int ID_W        = 16;
    localparam int ITEM_W      = 2;
    localparam int CHOICE_W    = 3;
    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 4;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ITEM_W-1:0] item;
    } entry_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PLACE   = 2'd0,
        ACT_PROCESS = 2'd1,
        ACT_CANCEL  = 2'd2,
        ACT_SEARCH  = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_PLACED       = 4'd0,
        STS_FULL         = 4'd1,
        STS_BAD_ITEM     = 4'd2,
        STS_SERVED_PRIO  = 4'd3,
        STS_SERVED_NORM  = 4'd4,
        STS_NONE_SERVE   = 4'd5,
        STS_CANCELLED    = 4'd6,
        STS_NONE_CANCEL  = 4'd7,
        STS_FOUND        = 4'd8,
        STS_NOT_FOUND    = 4'd9
    } status_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic search;
    } fifo_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic found;
    } fifo_stat_t;

endpackage

// ===== hw/rtl/tcpq_cmd_if.sv =====
// ----------------------------------------------------------------------------
// tcpq_cmd_if
// command channel of the order queue
// ----------------------------------------------------------------------------
interface tcpq_cmd_if;
    import tcpq_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0]     order_id;
    logic [CHOICE_W-1:0] item_choice;
    logic                priority_class;

    modport source (
        output valid,
        output action,
        output order_id,
        output item_choice,
        output priority_class,
        input  ready
    );

    modport sink (
        input  valid,
        input  action,
        input  order_id,
        input  item_choice,
        input  priority_class,
        output ready
    );
endinterface

// ===== hw/rtl/tcpq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tcpq_rsp_if
// result channel of the order queue
// ----------------------------------------------------------------------------
interface tcpq_rsp_if;
    import tcpq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     out_id;
    logic [ITEM_W-1:0]   out_item;
    logic                found_normal;
    logic                found_priority;

    modport source (
        output valid,
        output status,
        output out_id,
        output out_item,
        output found_normal,
        output found_priority,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  out_id,
        input  out_item,
        input  found_normal,
        input  found_priority,
        output ready
    );
endinterface

// ===== hw/rtl/tcpq_cell.sv =====
// ----------------------------------------------------------------------------
// tcpq_cell
// one queue slot: loads a new order, takes its neighbor's order on a pop,
// and registers an id match for searches
// ----------------------------------------------------------------------------
module tcpq_cell (
    input  logic                       clk,
    input  logic                       shift,
    input  logic                       load,
    input  logic                       capture,
    input  logic                       occupied,
    input  logic [tcpq_pkg::ID_W-1:0]  key,
    input  tcpq_pkg::entry_t           wr_entry,
    input  tcpq_pkg::entry_t           neighbor,
    output tcpq_pkg::entry_t           entry,
    output logic                       match
);
    import tcpq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   match_reg;
    logic   match_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (load)
        begin
            entry_next = wr_entry;
        end
        else if (shift)
        begin
            entry_next = neighbor;
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (capture)
        begin
            match_next = occupied && (entry_reg.id == key);
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;
endmodule

// ===== hw/rtl/tcpq_fifo.sv =====
// ----------------------------------------------------------------------------
// tcpq_fifo
// one order queue built as a row of cells, head in cell zero
// ----------------------------------------------------------------------------
`include "two_class_priority_order_queue_defines.svh"

module tcpq_fifo (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tcpq_pkg::fifo_ctrl_t       ctrl,
    input  tcpq_pkg::entry_t           wr_entry,
    input  logic [tcpq_pkg::ID_W-1:0]  key,
    output tcpq_pkg::entry_t           head,
    output tcpq_pkg::fifo_stat_t       stat
);
    import tcpq_pkg::*;

    cnt_t                   count_reg;
    cnt_t                   count_next;
    logic                   full;
    logic                   empty;
    entry_t                 cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] match;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        localparam int NB = (g == QUEUE_DEPTH - 1) ? g : g + 1;

        tcpq_cell u_cell (
            .clk      (clk),
            .shift    (ctrl.pop),
            .load     (ctrl.push && !full && (count_reg == CNT_W'(g))),
            .capture  (ctrl.search),
            .occupied (count_reg > CNT_W'(g)),
            .key      (key),
            .wr_entry (wr_entry),
            .neighbor (cell_entry[NB]),
            .entry    (cell_entry[g]),
            .match    (match[g])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push && !full)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop && !empty)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head       = cell_entry[0];
    assign stat.full  = full;
    assign stat.empty = empty;
    assign stat.found = |match;

    `TCPQ_ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, ctrl.pop, !empty)
    `TCPQ_ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    `TCPQ_ASSERT_NEXT(a_push_grows, clk, rst_n, rst_n && ctrl.push && !full, count_reg == $past(count_reg) + CNT_W'(1))
endmodule

// ===== hw/rtl/two_class_priority_order_queue.sv =====
// ----------------------------------------------------------------------------
// two_class_priority_order_queue
// priority and normal order queues with place, serve, cancel and id search
// ----------------------------------------------------------------------------
// place, process and cancel: result registered in the cycle after the transfer,
//   a new command every cycle while results are taken
// search: each queue cell registers its match flag, then the result is registered
//   from those flags in the search state; no new command is taken meanwhile
// reset: both queues empty and no result pending; slot contents are not cleared
`include "two_class_priority_order_queue_defines.svh"

module two_class_priority_order_queue (
    input  logic        clk,
    input  logic        rst_n,
    tcpq_cmd_if.sink    cmd,
    tcpq_rsp_if.source  rsp
);
    import tcpq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    status_t           status_reg;
    status_t           status_next;
    logic [ID_W-1:0]   id_reg;
    logic [ID_W-1:0]   id_next;
    logic [ITEM_W-1:0] item_reg;
    logic [ITEM_W-1:0] item_next;
    logic              fn_reg;
    logic              fn_next;
    logic              fp_reg;
    logic              fp_next;

    logic              out_free;
    logic              accept;
    action_t           act;
    logic              choice_ok;
    entry_t            wr_entry;
    fifo_ctrl_t        ctrl_n;
    fifo_ctrl_t        ctrl_p;
    entry_t            head_n;
    entry_t            head_p;
    fifo_stat_t        stat_n;
    fifo_stat_t        stat_p;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = cmd.valid && cmd.ready;
    assign act       = action_t'(cmd.action);
    assign choice_ok = (cmd.item_choice != '0)
                       && (cmd.item_choice <= CHOICE_W'(MENU_SIZE));

    assign wr_entry.id   = cmd.order_id;
    assign wr_entry.item = ITEM_W'(cmd.item_choice - CHOICE_W'(1));

    tcpq_fifo u_normal (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl_n),
        .wr_entry (wr_entry),
        .key      (cmd.order_id),
        .head     (head_n),
        .stat     (stat_n)
    );

    tcpq_fifo u_priority (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl_p),
        .wr_entry (wr_entry),
        .key      (cmd.order_id),
        .head     (head_p),
        .stat     (stat_p)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        id_next        = id_reg;
        item_next      = item_reg;
        fn_next        = fn_reg;
        fp_next        = fp_reg;
        ctrl_n         = '0;
        ctrl_p         = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            id_next   = '0;
            item_next = '0;
            fn_next   = 1'b0;
            fp_next   = 1'b0;
            case (act)
                ACT_PLACE:
                begin
                    out_valid_next = 1'b1;
                    if (!choice_ok)
                    begin
                        status_next = STS_BAD_ITEM;
                    end
                    else if (cmd.priority_class ? stat_p.full : stat_n.full)
                    begin
                        status_next = STS_FULL;
                    end
                    else
                    begin
                        status_next = STS_PLACED;
                        ctrl_p.push = cmd.priority_class;
                        ctrl_n.push = !cmd.priority_class;
                    end
                end
                ACT_PROCESS:
                begin
                    out_valid_next = 1'b1;
                    if (!stat_p.empty)
                    begin
                        status_next = STS_SERVED_PRIO;
                        id_next     = head_p.id;
                        item_next   = head_p.item;
                        ctrl_p.pop  = 1'b1;
                    end
                    else if (!stat_n.empty)
                    begin
                        status_next = STS_SERVED_NORM;
                        id_next     = head_n.id;
                        item_next   = head_n.item;
                        ctrl_n.pop  = 1'b1;
                    end
                    else
                    begin
                        status_next = STS_NONE_SERVE;
                    end
                end
                ACT_CANCEL:
                begin
                    out_valid_next = 1'b1;
                    if (!stat_n.empty)
                    begin
                        status_next = STS_CANCELLED;
                        id_next     = head_n.id;
                        item_next   = head_n.item;
                        ctrl_n.pop  = 1'b1;
                    end
                    else
                    begin
                        status_next = STS_NONE_CANCEL;
                    end
                end
                ACT_SEARCH:
                begin
                    ctrl_n.search = 1'b1;
                    ctrl_p.search = 1'b1;
                    state_next    = S_SEARCH;
                end
                default:
                begin
                    status_next = STS_NOT_FOUND;
                end
            endcase
        end

        if ((state_reg == S_SEARCH) && out_free)
        begin
            out_valid_next = 1'b1;
            status_next    = (stat_n.found || stat_p.found) ? STS_FOUND : STS_NOT_FOUND;
            id_next        = '0;
            item_next      = '0;
            fn_next        = stat_n.found;
            fp_next        = stat_p.found;
            state_next     = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            status_reg    <= STS_PLACED;
            id_reg        <= '0;
            item_reg      <= '0;
            fn_reg        <= 1'b0;
            fp_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            id_reg        <= id_next;
            item_reg      <= item_next;
            fn_reg        <= fn_next;
            fp_reg        <= fp_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.out_id         = id_reg;
    assign rsp.out_item       = item_reg;
    assign rsp.found_normal   = fn_reg;
    assign rsp.found_priority = fp_reg;

    `TCPQ_ASSERT_IMPLIES(a_search_blocks, clk, rst_n, state_reg == S_SEARCH, !cmd.ready)
    `TCPQ_ASSERT_NEXT(a_result_follows, clk, rst_n, rst_n && accept && (act != ACT_SEARCH), out_valid_reg)
    `TCPQ_ASSERT_NEXT(a_search_waits, clk, rst_n, rst_n && accept && (act == ACT_SEARCH), state_reg == S_SEARCH)
endmodule

// ===== dv/tcpq_order_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcpq_order_checker
// watches the command and result channels of the order queue, keeps its own
// copy of both queues, predicts the outcome of every accepted command and
// compares each result with the oldest pending prediction, field by field
// ----------------------------------------------------------------------------
module tcpq_order_checker (
    input  logic        clk,
    input  logic        rst_n,
    tcpq_cmd_if         cmd_mon,
    tcpq_rsp_if         rsp_mon,
    output int unsigned fail_count,
    output int unsigned result_count,
    output int unsigned pending_count
);
    import tcpq_pkg::*;

    localparam int unsigned MAX_REPORTS = 30;

    typedef struct {
        status_t           status;
        logic [ID_W-1:0]   id;
        logic [ITEM_W-1:0] item;
        logic              in_normal;
        logic              in_priority;
    } order_outcome_t;

    entry_t         normal_orders[$];
    entry_t         priority_orders[$];
    order_outcome_t expected_outcomes[$];
    int unsigned    mismatches;
    int unsigned    compared;

    task automatic report_mismatch(input string what, input logic [ID_W-1:0] got,
                                   input logic [ID_W-1:0] want);
        if (mismatches < MAX_REPORTS)
            $display("%0t: mismatch in %s at result %0d: got 0x%0h, expected 0x%0h",
                     $realtime, what, compared, got, want);
        mismatches++;
    endtask

    function automatic order_outcome_t predict_outcome(input action_t act,
                                                       input logic [ID_W-1:0] id,
                                                       input logic [CHOICE_W-1:0] choice,
                                                       input logic to_priority);
        order_outcome_t outcome;
        entry_t         slot;
        outcome = '{status: STS_PLACED, id: '0, item: '0, in_normal: 1'b0,
                    in_priority: 1'b0};
        case (act)
            ACT_PLACE:
            begin
                if (choice < 1 || choice > MENU_SIZE)
                    outcome.status = STS_BAD_ITEM;
                else if ((to_priority ? priority_orders.size() : normal_orders.size())
                         >= QUEUE_DEPTH)
                    outcome.status = STS_FULL;
                else
                begin
                    slot.id   = id;
                    slot.item = ITEM_W'(choice - 1);
                    if (to_priority)
                        priority_orders.push_back(slot);
                    else
                        normal_orders.push_back(slot);
                end
            end
            ACT_PROCESS:
            begin
                if (priority_orders.size() > 0)
                begin
                    slot           = priority_orders.pop_front();
                    outcome.status = STS_SERVED_PRIO;
                    outcome.id     = slot.id;
                    outcome.item   = slot.item;
                end
                else if (normal_orders.size() > 0)
                begin
                    slot           = normal_orders.pop_front();
                    outcome.status = STS_SERVED_NORM;
                    outcome.id     = slot.id;
                    outcome.item   = slot.item;
                end
                else
                    outcome.status = STS_NONE_SERVE;
            end
            ACT_CANCEL:
            begin
                if (normal_orders.size() > 0)
                begin
                    slot           = normal_orders.pop_front();
                    outcome.status = STS_CANCELLED;
                    outcome.id     = slot.id;
                    outcome.item   = slot.item;
                end
                else
                    outcome.status = STS_NONE_CANCEL;
            end
            ACT_SEARCH:
            begin
                foreach (normal_orders[k])
                    if (normal_orders[k].id == id)
                        outcome.in_normal = 1'b1;
                foreach (priority_orders[k])
                    if (priority_orders[k].id == id)
                        outcome.in_priority = 1'b1;
                outcome.status = (outcome.in_normal || outcome.in_priority) ?
                                 STS_FOUND : STS_NOT_FOUND;
            end
        endcase
        return outcome;
    endfunction

    task automatic check_outcome();
        order_outcome_t want;
        if (expected_outcomes.size() == 0)
        begin
            report_mismatch("result with nothing pending", ID_W'(rsp_mon.status), '0);
            return;
        end
        want = expected_outcomes.pop_front();
        if (rsp_mon.status !== want.status)
            report_mismatch("status", ID_W'(rsp_mon.status), ID_W'(want.status));
        if (rsp_mon.out_id !== want.id)
            report_mismatch("out_id", rsp_mon.out_id, want.id);
        if (rsp_mon.out_item !== want.item)
            report_mismatch("out_item", ID_W'(rsp_mon.out_item), ID_W'(want.item));
        if (rsp_mon.found_normal !== want.in_normal)
            report_mismatch("found_normal", ID_W'(rsp_mon.found_normal),
                            ID_W'(want.in_normal));
        if (rsp_mon.found_priority !== want.in_priority)
            report_mismatch("found_priority", ID_W'(rsp_mon.found_priority),
                            ID_W'(want.in_priority));
        compared++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_orders.delete();
            priority_orders.delete();
            expected_outcomes.delete();
            mismatches = 0;
            compared   = 0;
            fail_count    <= 0;
            result_count  <= 0;
            pending_count <= 0;
        end
        else
        begin
            // results first: a command accepted at this edge cannot answer yet
            if (rsp_mon.valid && rsp_mon.ready)
                check_outcome();
            if (cmd_mon.valid && cmd_mon.ready)
                expected_outcomes.push_back(predict_outcome(action_t'(cmd_mon.action),
                                                            cmd_mon.order_id,
                                                            cmd_mon.item_choice,
                                                            cmd_mon.priority_class));
            fail_count    <= mismatches;
            result_count  <= compared;
            pending_count <= expected_outcomes.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives the order queue with a directed opening and random bursts of
// fills, drains, mixed traffic, searches and noise under three idle mixes,
// stalls the result channel at random and reports the checker's verdict
// ----------------------------------------------------------------------------
module tb_top;
    import tcpq_pkg::*;

    localparam int unsigned ITEMS_PER_PHASE = 220;
    localparam int unsigned SETTLE_CYCLES   = 10;
    localparam int unsigned RECENT_IDS      = 24;

    typedef enum int {
        BURST_FILL,
        BURST_DRAIN,
        BURST_MIXED,
        BURST_SEARCH,
        BURST_NOISE
    } burst_t;

    logic clk;
    logic rst_n;

    tcpq_cmd_if cmd_ch ();
    tcpq_rsp_if rsp_ch ();

    int unsigned fail_count;
    int unsigned result_count;
    int unsigned pending_count;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned sent_total;
    int unsigned sent_per_action[4];
    logic [ID_W-1:0] recent_ids[$];

    two_class_priority_order_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    tcpq_order_checker order_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_mon       (cmd_ch),
        .rsp_mon       (rsp_ch),
        .fail_count    (fail_count),
        .result_count  (result_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("timeout with %0d results still pending", pending_count);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [CHOICE_W-1:0] good_choice();
        return CHOICE_W'($urandom_range(1, MENU_SIZE));
    endfunction

    function automatic logic [CHOICE_W-1:0] bad_choice();
        int unsigned r;
        r = $urandom_range(MENU_SIZE, (1 << CHOICE_W) - 1);
        return (r == MENU_SIZE) ? '0 : CHOICE_W'(r);
    endfunction

    function automatic logic [CHOICE_W-1:0] random_choice();
        return ($urandom_range(9) == 0) ? bad_choice() : good_choice();
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35 && recent_ids.size() > 0)
            return recent_ids[$urandom_range(recent_ids.size() - 1)];
        if (r < 60)
            return ID_W'($urandom_range(7));
        return ID_W'($urandom);
    endfunction

    function automatic burst_t pick_burst();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15)
            return BURST_FILL;
        if (r < 35)
            return BURST_DRAIN;
        if (r < 75)
            return BURST_MIXED;
        if (r < 88)
            return BURST_SEARCH;
        return BURST_NOISE;
    endfunction

    task automatic send_command(input action_t act, input logic [ID_W-1:0] id,
                                input logic [CHOICE_W-1:0] choice, input logic cls);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.action         <= act;
        cmd_ch.order_id       <= id;
        cmd_ch.item_choice    <= choice;
        cmd_ch.priority_class <= cls;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        sent_total++;
        sent_per_action[act]++;
        if (act == ACT_PLACE)
        begin
            recent_ids.push_back(id);
            if (recent_ids.size() > RECENT_IDS)
                void'(recent_ids.pop_front());
        end
    endtask

    // full queue, then a bad choice and a good one against it
    task automatic fill_queue(input logic cls);
        repeat (QUEUE_DEPTH)
            send_command(ACT_PLACE, pick_id(), good_choice(), cls);
        send_command(ACT_PLACE, pick_id(), bad_choice(), cls);
        send_command(ACT_PLACE, pick_id(), good_choice(), cls);
    endtask

    task automatic run_burst(input burst_t kind);
        int unsigned r;
        case (kind)
            BURST_FILL:
                fill_queue(1'($urandom_range(1)));
            BURST_DRAIN:
                repeat ($urandom_range(4, QUEUE_DEPTH + 4))
                    send_command(($urandom_range(3) == 0) ? ACT_CANCEL : ACT_PROCESS,
                                 ID_W'($urandom), CHOICE_W'($urandom),
                                 1'($urandom_range(1)));
            BURST_MIXED:
                repeat ($urandom_range(4, 12))
                begin
                    r = $urandom_range(99);
                    if (r < 40)
                        send_command(ACT_PLACE, pick_id(), random_choice(),
                                     1'($urandom_range(1)));
                    else if (r < 60)
                        send_command(ACT_PROCESS, ID_W'($urandom), CHOICE_W'($urandom),
                                     1'($urandom_range(1)));
                    else if (r < 75)
                        send_command(ACT_CANCEL, ID_W'($urandom), CHOICE_W'($urandom),
                                     1'($urandom_range(1)));
                    else
                        send_command(ACT_SEARCH, pick_id(), CHOICE_W'($urandom),
                                     1'($urandom_range(1)));
                end
            BURST_SEARCH:
                repeat ($urandom_range(4, 8))
                    send_command(ACT_SEARCH, pick_id(), CHOICE_W'($urandom),
                                 1'($urandom_range(1)));
            BURST_NOISE:
                repeat ($urandom_range(2, 6))
                    send_command(action_t'($urandom_range(3)), ID_W'($urandom),
                                 CHOICE_W'($urandom), 1'($urandom_range(1)));
        endcase
    endtask

    task automatic wait_for_results();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n                 <= 1'b0;
        cmd_ch.valid          <= 1'b0;
        cmd_ch.action         <= ACT_PLACE;
        cmd_ch.order_id       <= '0;
        cmd_ch.item_choice    <= '0;
        cmd_ch.priority_class <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sent_total     = 0;
        foreach (sent_per_action[a])
            sent_per_action[a] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // empty queues, bad choices, id extremes, every action
        send_command(ACT_PROCESS, 16'h0000, 3'd0, 1'b0);
        send_command(ACT_CANCEL,  16'h0000, 3'd0, 1'b0);
        send_command(ACT_SEARCH,  16'h0000, 3'd0, 1'b0);
        send_command(ACT_PLACE,   16'hFFFF, 3'd0, 1'b1);
        send_command(ACT_PLACE,   16'h0000, 3'd7, 1'b0);
        send_command(ACT_PLACE,   16'h5A5A, 3'd5, 1'b0);
        send_command(ACT_PLACE,   16'h0000, 3'd1, 1'b0);
        send_command(ACT_PLACE,   16'hFFFF, 3'd4, 1'b0);
        send_command(ACT_PLACE,   16'h1234, 3'd2, 1'b1);
        send_command(ACT_PLACE,   16'hFFFF, 3'd3, 1'b1);
        send_command(ACT_SEARCH,  16'hFFFF, 3'd7, 1'b1);
        send_command(ACT_SEARCH,  16'h0000, 3'd0, 1'b0);
        send_command(ACT_SEARCH,  16'h1234, 3'd0, 1'b0);
        send_command(ACT_SEARCH,  16'hABCD, 3'd0, 1'b0);
        send_command(ACT_CANCEL,  16'hFFFF, 3'd7, 1'b1);
        send_command(ACT_PROCESS, 16'hFFFF, 3'd7, 1'b1);
        send_command(ACT_PROCESS, 16'h0000, 3'd0, 1'b0);
        send_command(ACT_PROCESS, 16'h0000, 3'd0, 1'b0);
        send_command(ACT_PROCESS, 16'h0000, 3'd0, 1'b0);
        send_command(ACT_CANCEL,  16'h0000, 3'd0, 1'b0);
        send_command(ACT_PLACE,   16'hA5A5, 3'd6, 1'b1);
        send_command(ACT_PLACE,   16'hA5A5, 3'd4, 1'b1);
        send_command(ACT_SEARCH,  16'hA5A5, 3'd0, 1'b0);
        wait_for_results();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 50;
                end
                1:
                begin
                    send_idle_pct  = 50;
                    recv_stall_pct = 22;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            if (phase == 0)
            begin
                fill_queue(1'b1);
                fill_queue(1'b0);
            end
            while (sent_total < 23 + (phase + 1) * ITEMS_PER_PHASE)
                run_burst(pick_burst());
            wait_for_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d commands: %0d place, %0d process, %0d cancel, %0d search",
                 sent_total, sent_per_action[ACT_PLACE], sent_per_action[ACT_PROCESS],
                 sent_per_action[ACT_CANCEL], sent_per_action[ACT_SEARCH]);
        $display("%0d results compared over three idle mixes, both queues run past full",
                 result_count);
        if (fail_count == 0 && pending_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
